// ----- hw/rtl/kfi_pkg.sv -----
// kfi_pkg: shared types and constants for the keyframe interpolator.
// Item and result structs, key table row, microcode step/uop/condition codes.
// No dependencies.
package kfi_pkg;

  localparam int MAX_KEYS   = 64;
  localparam int KEY_ADDR_W = $clog2(MAX_KEYS);
  localparam int CNT_W      = 7;       // key_count register width
  localparam int TIME_W     = 24;      // unsigned Q16.8
  localparam int VAL_W      = 32;      // signed Q16.16
  localparam int FRAC_W     = 16;      // factor, Q0.16
  localparam int DIV_CNT_W  = $clog2(FRAC_W);
  localparam int PROD_W     = VAL_W + FRAC_W + 2;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  typedef struct packed {
    logic                  opcode;
    logic [KEY_ADDR_W-1:0] key_index;
    logic [TIME_W-1:0]     key_time;
    logic signed [VAL_W-1:0] value_x;
    logic signed [VAL_W-1:0] value_y;
    logic signed [VAL_W-1:0] value_z;
    logic [TIME_W-1:0]     sample_time;
  } in_item_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] out_x;
    logic signed [VAL_W-1:0] out_y;
    logic signed [VAL_W-1:0] out_z;
    logic [KEY_ADDR_W-1:0]   segment_start;
    logic                    held_last;
  } out_item_t;

  typedef struct packed {
    logic [TIME_W-1:0]       key_time;
    logic signed [VAL_W-1:0] key_x;
    logic signed [VAL_W-1:0] key_y;
    logic signed [VAL_W-1:0] key_z;
  } key_row_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_PRIME, ST_SCAN, ST_SCAN_EXIT, ST_HOLD_RD, ST_HOLD_OUT,
    ST_LOAD_A, ST_LOAD_B, ST_LOAD_C, ST_FACTOR, ST_DIV,
    ST_MUL_X, ST_MUL_Y, ST_MUL_Z, ST_MIX_OUT
  } step_t;

  typedef enum logic [3:0] {
    U_ACCEPT, U_PRIME, U_SCAN, U_SEG, U_HOLD_RD, U_HOLD_OUT,
    U_RD_SEG, U_RD_SEG1, U_LATCH_B, U_FACTOR, U_DIV,
    U_MUL_X, U_MUL_Y, U_MUL_Z, U_MIX_OUT
  } uop_t;

  typedef enum logic [2:0] {
    C_NEVER, C_ALWAYS, C_NOT_SAMPLE, C_ONE_KEY,
    C_SCAN_MORE, C_FOUND, C_NO_DIV, C_DIV_MORE
  } cond_t;

  typedef struct packed {
    uop_t  uop;
    cond_t cond;
    step_t target;
  } ucode_t;

  typedef struct packed {
    uop_t uop;
  } ctrl_t;

  typedef struct packed {
    logic one_key;
    logic scan_more;
    logic found;
    logic no_div;
    logic div_more;
  } status_t;

endpackage

// ----- hw/rtl/kfi_key_mem.sv -----
// kfi_key_mem: key table, one write port and one registered read port.
// Depends on kfi_pkg.
module kfi_key_mem (
  input  logic                          clk,
  input  logic                          we,
  input  logic [kfi_pkg::KEY_ADDR_W-1:0] waddr,
  input  kfi_pkg::key_row_t             wdata,
  input  logic [kfi_pkg::KEY_ADDR_W-1:0] raddr,
  output kfi_pkg::key_row_t             rdata
);
  import kfi_pkg::*;

  key_row_t mem [MAX_KEYS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/kfi_sequencer.sv -----
// kfi_sequencer: step counter plus microcode ROM with conditional jumps.
// Depends on kfi_pkg.
module kfi_sequencer (
  input  logic             clk,
  input  logic             rst,
  input  logic             sample_go,
  input  kfi_pkg::status_t status,
  output kfi_pkg::ctrl_t   ctrl,
  output logic             busy
);
  import kfi_pkg::*;

  step_t  step;
  step_t  step_next;
  ucode_t word;
  logic   take;

  // program: uop, jump condition, jump target (else fall through)
  always_comb begin
    case (step)
      ST_IDLE:      word = '{U_ACCEPT,   C_NOT_SAMPLE, ST_IDLE};
      ST_PRIME:     word = '{U_PRIME,    C_ONE_KEY,    ST_HOLD_RD};
      ST_SCAN:      word = '{U_SCAN,     C_SCAN_MORE,  ST_SCAN};
      ST_SCAN_EXIT: word = '{U_SEG,      C_FOUND,      ST_LOAD_A};
      ST_HOLD_RD:   word = '{U_HOLD_RD,  C_NEVER,      ST_IDLE};
      ST_HOLD_OUT:  word = '{U_HOLD_OUT, C_ALWAYS,     ST_IDLE};
      ST_LOAD_A:    word = '{U_RD_SEG,   C_NEVER,      ST_IDLE};
      ST_LOAD_B:    word = '{U_RD_SEG1,  C_NEVER,      ST_IDLE};
      ST_LOAD_C:    word = '{U_LATCH_B,  C_NEVER,      ST_IDLE};
      ST_FACTOR:    word = '{U_FACTOR,   C_NO_DIV,     ST_MUL_X};
      ST_DIV:       word = '{U_DIV,      C_DIV_MORE,   ST_DIV};
      ST_MUL_X:     word = '{U_MUL_X,    C_NEVER,      ST_IDLE};
      ST_MUL_Y:     word = '{U_MUL_Y,    C_NEVER,      ST_IDLE};
      ST_MUL_Z:     word = '{U_MUL_Z,    C_NEVER,      ST_IDLE};
      ST_MIX_OUT:   word = '{U_MIX_OUT,  C_ALWAYS,     ST_IDLE};
      default:      word = '{U_ACCEPT,   C_ALWAYS,     ST_IDLE};
    endcase
  end

  always_comb begin
    case (word.cond)
      C_NEVER:      take = 1'b0;
      C_ALWAYS:     take = 1'b1;
      C_NOT_SAMPLE: take = !sample_go;
      C_ONE_KEY:    take = status.one_key;
      C_SCAN_MORE:  take = status.scan_more;
      C_FOUND:      take = status.found;
      C_NO_DIV:     take = status.no_div;
      C_DIV_MORE:   take = status.div_more;
      default:      take = 1'b1;
    endcase
  end

  always_comb begin
    step_next = take ? word.target : step_t'(4'(step) + 4'd1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= ST_IDLE;
    end else begin
      step <= step_next;
    end
  end

  always_comb begin
    ctrl.uop = word.uop;
    busy     = (step != ST_IDLE);
  end

endmodule

// ----- hw/rtl/kfi_datapath.sv -----
// kfi_datapath: search index, key registers, restoring divider, shared
// multiplier and result register, all steered by the microcode uop.
// Depends on kfi_pkg.
module kfi_datapath (
  input  logic                           clk,
  input  logic                           rst,
  input  kfi_pkg::ctrl_t                 ctrl,
  input  kfi_pkg::in_item_t              request,
  input  logic [kfi_pkg::CNT_W-1:0]      key_count,
  input  kfi_pkg::key_row_t              rdata,
  output logic [kfi_pkg::KEY_ADDR_W-1:0] rd_addr,
  output kfi_pkg::status_t               status,
  output kfi_pkg::out_item_t             result,
  output logic                           done
);
  import kfi_pkg::*;

  logic [TIME_W-1:0]       samp_t;
  logic [CNT_W-1:0]        n;
  logic [CNT_W-1:0]        n_in;
  logic [CNT_W-1:0]        idx;
  logic [CNT_W-1:0]        idx_m2;
  logic [CNT_W-1:0]        n_m1;
  logic                    found_r;
  logic                    found_now;
  logic [KEY_ADDR_W-1:0]   seg;
  logic [KEY_ADDR_W-1:0]   seg_p1;
  logic [TIME_W-1:0]       t0, t1, span, rem;
  logic [TIME_W:0]         rem_dbl;
  logic                    rem_ge;
  logic [TIME_W-1:0]       rem_next;
  logic [FRAC_W-1:0]       quot, quot_next, f, f_trivial;
  logic [DIV_CNT_W-1:0]    cnt;
  logic signed [VAL_W-1:0] a_x, a_y, a_z, b_x, b_y, b_z;
  logic signed [VAL_W-1:0] ma, mb, mix_a;
  logic signed [VAL_W:0]   diff;
  logic signed [PROD_W-1:0] prod, prod_next;
  logic signed [VAL_W+1:0] mix_sum;
  logic                    t1_gt, off_pos, reach;
  out_item_t               res;

  // clamp key count into 1..MAX_KEYS
  always_comb begin
    if (key_count == '0) begin
      n_in = CNT_W'(1);
    end else if (key_count > CNT_W'(MAX_KEYS)) begin
      n_in = CNT_W'(MAX_KEYS);
    end else begin
      n_in = key_count;
    end
  end

  assign idx_m2    = idx - CNT_W'(2);
  assign n_m1      = n - CNT_W'(1);
  assign seg_p1    = seg + KEY_ADDR_W'(1);
  assign found_now = samp_t < rdata.key_time;

  always_comb begin
    case (ctrl.uop)
      U_HOLD_RD: rd_addr = n_m1[KEY_ADDR_W-1:0];
      U_RD_SEG:  rd_addr = seg;
      U_RD_SEG1: rd_addr = seg_p1;
      default:   rd_addr = idx[KEY_ADDR_W-1:0];
    endcase
  end

  // factor shortcuts: flat span or before start -> 0, at/after end -> all ones
  assign t1_gt     = t1 > t0;
  assign off_pos   = samp_t > t0;
  assign reach     = samp_t >= t1;
  assign f_trivial = (t1_gt && off_pos) ? '1 : '0;

  // restoring division, one quotient bit per step
  assign rem_dbl   = {rem, 1'b0};
  assign rem_ge    = rem_dbl >= {1'b0, span};
  assign rem_next  = rem_ge ? TIME_W'(rem_dbl - {1'b0, span}) : rem_dbl[TIME_W-1:0];
  assign quot_next = {quot[FRAC_W-2:0], rem_ge};

  always_comb begin
    case (ctrl.uop)
      U_MUL_X: begin
        ma = a_x;
        mb = b_x;
      end
      U_MUL_Y: begin
        ma = a_y;
        mb = b_y;
      end
      default: begin
        ma = a_z;
        mb = b_z;
      end
    endcase
  end

  always_comb begin
    case (ctrl.uop)
      U_MUL_Y: mix_a = a_x;
      U_MUL_Z: mix_a = a_y;
      default: mix_a = a_z;
    endcase
  end

  // a + floor((b - a) * f / 2^16); stays between a and b, so no overflow
  assign diff      = {mb[VAL_W-1], mb} - {ma[VAL_W-1], ma};
  assign prod_next = diff * $signed({1'b0, f});
  assign mix_sum   = {{2{mix_a[VAL_W-1]}}, mix_a} + prod[PROD_W-1:FRAC_W];

  always_comb begin
    status.one_key   = (n == CNT_W'(1));
    status.scan_more = !found_now && (idx != n);
    status.found     = found_r;
    status.no_div    = !t1_gt || !off_pos || reach;
    status.div_more  = (cnt != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (ctrl.uop == U_HOLD_OUT) || (ctrl.uop == U_MIX_OUT);
    end
  end

  always_ff @(posedge clk) begin
    case (ctrl.uop)
      U_ACCEPT: begin
        samp_t <= request.sample_time;
        n      <= n_in;
        idx    <= CNT_W'(1);
      end
      U_PRIME: begin
        idx <= idx + CNT_W'(1);
      end
      U_SCAN: begin
        found_r <= found_now;
        if (status.scan_more) begin
          idx <= idx + CNT_W'(1);
        end
      end
      U_SEG: begin
        seg <= idx_m2[KEY_ADDR_W-1:0];
      end
      U_HOLD_RD: begin
        seg <= n_m1[KEY_ADDR_W-1:0];
      end
      U_HOLD_OUT: begin
        res.out_x         <= rdata.key_x;
        res.out_y         <= rdata.key_y;
        res.out_z         <= rdata.key_z;
        res.segment_start <= seg;
        res.held_last     <= 1'b1;
      end
      U_RD_SEG: begin
      end
      U_RD_SEG1: begin
        t0  <= rdata.key_time;
        a_x <= rdata.key_x;
        a_y <= rdata.key_y;
        a_z <= rdata.key_z;
      end
      U_LATCH_B: begin
        t1  <= rdata.key_time;
        b_x <= rdata.key_x;
        b_y <= rdata.key_y;
        b_z <= rdata.key_z;
      end
      U_FACTOR: begin
        span <= t1 - t0;
        rem  <= samp_t - t0;
        quot <= '0;
        cnt  <= DIV_CNT_W'(FRAC_W - 1);
        f    <= f_trivial;
      end
      U_DIV: begin
        rem  <= rem_next;
        quot <= quot_next;
        f    <= quot_next;
        cnt  <= cnt - DIV_CNT_W'(1);
      end
      U_MUL_X: begin
        prod <= prod_next;
      end
      U_MUL_Y: begin
        res.out_x <= mix_sum[VAL_W-1:0];
        prod      <= prod_next;
      end
      U_MUL_Z: begin
        res.out_y <= mix_sum[VAL_W-1:0];
        prod      <= prod_next;
      end
      U_MIX_OUT: begin
        res.out_z         <= mix_sum[VAL_W-1:0];
        res.segment_start <= seg;
        res.held_last     <= 1'b0;
      end
      default: begin
      end
    endcase
  end

  assign result = res;

endmodule

// ----- hw/rtl/vec3_keyframe_interpolator.sv -----
// vec3_keyframe_interpolator: top level of the linear keyframe interpolator.
// Depends on kfi_pkg, kfi_key_mem, kfi_sequencer, kfi_datapath.
//
//   channel  | handshake          | payload            | notes
//   ---------+--------------------+--------------------+---------------------------
//   item in  | start & !busy      | request (in_item_t)| opcode 0 key write, 1 sample
//   result   | done (1 cycle)     | result (out_item_t)| one per sample, none per write
//   config   | cfg_we             | cfg_data (7 bits)  | key_count, write while idle
//
// A key write lands in the table as it is accepted and leaves busy low. A
// sample runs through the microcode: a linear search that compares keys 1 to
// n-1 at most, then SCAN_EXIT, LOAD_A, LOAD_B and LOAD_C to fetch both keys, a
// 16-bit restoring division for the factor (skipped when it clamps to 0 or all
// ones), and MUL_X, MUL_Y, MUL_Z and MIX_OUT on one shared multiplier for x, y
// and z. A held last key runs through HOLD_RD and HOLD_OUT, straight after PRIME
// with a single key. The single table read port sets the search pace. Reset
// (synchronous, rst high) returns the sequencer to idle and key_count to 1; the
// key table is not cleared. The result strobe cannot be held off, so there is
// no output stall.
module vec3_keyframe_interpolator (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  kfi_pkg::in_item_t         request,
  input  logic                      cfg_we,
  input  logic [kfi_pkg::CNT_W-1:0] cfg_data,
  output kfi_pkg::out_item_t        result,
  output logic                      done
);
  import kfi_pkg::*;

  logic [CNT_W-1:0]      key_count;
  logic                  key_we;
  logic                  sample_go;
  key_row_t              wrow;
  key_row_t              rdata;
  logic [KEY_ADDR_W-1:0] rd_addr;
  ctrl_t                 ctrl;
  status_t               status;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      key_count <= CNT_W'(1);
    end else if (cfg_we) begin
      key_count <= cfg_data;
    end
  end

  // a key write lands in the table on the accepting edge
  assign key_we    = start && !busy && (request.opcode == OP_WRITE);
  assign sample_go = start && !busy && (request.opcode == OP_SAMPLE);

  always_comb begin
    wrow.key_time = request.key_time;
    wrow.key_x    = request.value_x;
    wrow.key_y    = request.value_y;
    wrow.key_z    = request.value_z;
  end

  kfi_key_mem u_mem (
    .clk   (clk),
    .we    (key_we),
    .waddr (request.key_index),
    .wdata (wrow),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  kfi_sequencer u_seq (
    .clk       (clk),
    .rst       (rst),
    .sample_go (sample_go),
    .status    (status),
    .ctrl      (ctrl),
    .busy      (busy)
  );

  kfi_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .request   (request),
    .key_count (key_count),
    .rdata     (rdata),
    .rd_addr   (rd_addr),
    .status    (status),
    .result    (result),
    .done      (done)
  );

  // result strobe only fires as the sequencer drops back to idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("result strobe while busy");

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy)) else $error("result strobe without work");

  // only a sample starts the sequencer
  a_busy_from_sample: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start && request.opcode == OP_SAMPLE))
    else $error("sequencer started without a sample item");

  a_write_no_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && request.opcode == OP_WRITE) |=> (!busy && !done))
    else $error("key write started work");

endmodule
